FILE: design/omni_wheel_speed_to_pwm_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the omni wheel speed to PWM block
// Clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef OMNI_WHEEL_SPEED_TO_PWM_MACROS_SVH
`define OMNI_WHEEL_SPEED_TO_PWM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWSP_CHECK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("omni wheel check failed");

// The consequent must hold in the cycle after the antecedent.
`define OWSP_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("omni wheel check failed");

`endif

FILE: design/owsp_pkg.sv
// ---------------------------------------------------------------------------
// owsp_pkg
// Shared constants and types of the omni wheel speed to PWM block.
// ---------------------------------------------------------------------------
package owsp_pkg;

	localparam int SPEED_W = 12;
	localparam int HEAD_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int RPM_W   = 11;
	localparam int DUTY_W  = 8;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 64;

	// Quarter-wave sine polynomial in Q30.
	localparam int Q_W = 31;
	localparam logic [Q_W-1:0] SIN_C11 = 31'd3864;
	localparam int HORNER_CELLS = 5;
	localparam logic [Q_W-1:0] HORNER_COEF [HORNER_CELLS] = '{
		31'd172272, 31'd5026996, 31'd85569306, 31'd693598669, 31'd1686629713
	};

	localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

	// Wheel sums are TRIG_BITS + SUM_GUARD bits wide.
	localparam int SUM_GUARD = 30;
	localparam int LO_W      = 24;
	localparam int P_W       = 12;
	localparam logic [P_W-1:0] RPM_POS_MAX = 12'd1023;
	localparam logic [P_W-1:0] RPM_NEG_MAX = 12'd1024;
	localparam logic [P_W-1:0] DUTY_MAX    = 12'd255;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN = 1'd1;
	localparam logic [GAIN_W-1:0] RPM_GAIN_RST  = 16'd15647;
	localparam logic [GAIN_W-1:0] DUTY_GAIN_RST = 16'd41779;

	typedef struct packed {
		logic en_abs;
		logic en_mul;
		logic en_sum;
		logic en_out;
	} owsp_wheel_ctrl_t;

endpackage

FILE: design/omni_wheel_speed_to_pwm.sv
// ---------------------------------------------------------------------------
// omni_wheel_speed_to_pwm
// Three-wheel omni drive: speed and heading to wheel rpm, PWM duty, direction.
// ---------------------------------------------------------------------------
// A command item on the s_ side carries a signed speed in mm/s and a heading
// as a binary angle. Each command gives one result item on the m_ side with
// rpm, duty and forward bit for wheels A, B and C.
// The datapath is a fifteen-stage pipeline: quadrant fold, square, five Horner
// cells per trig lane, sine finish, two multiply stages, the wheel sums and
// four stages per wheel. One item is accepted each cycle that s_tready is high.
// Every stage holds a valid bit and loads when it is empty or the stage after
// it moves, so bubbles close up while the receiver stalls; s_tready falls only
// when all fifteen stages hold items. A stalled result holds steady. Reset
// empties the pipeline and loads the default gains. The gains are written
// through cfg_we, cfg_index and cfg_wdata; the user must write them only while
// no item is in flight, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module omni_wheel_speed_to_pwm
	import owsp_pkg::*;
#(
	parameter int TRIG_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// speed_mm_s [11:0], heading [27:12], zero [31:28]
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// rpm_wheel_a, rpm_wheel_b, rpm_wheel_c, duty_a, duty_b, duty_c,
	// forward_a, forward_b, forward_c, zero [63:60]
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int NSTG  = 15;
	localparam int VC_W  = TRIG_BITS + SPEED_W;
	localparam int SUM_W = TRIG_BITS + SUM_GUARD;
	localparam int CELL0 = 3;
	localparam logic [TRIG_BITS:0] SIN_TOP = (TRIG_BITS+1)'((1 << (TRIG_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] K_SQ3 = SUM_W'(SQRT3_HALF_Q16);

	logic [GAIN_W-1:0] rpm_gain_q;
	logic [GAIN_W-1:0] duty_gain_q;
	logic [NSTG:1]     vld_q;
	logic [NSTG:1]     en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_gain_q  <= RPM_GAIN_RST;
			duty_gain_q <= DUTY_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RPM_GAIN:  rpm_gain_q  <= cfg_wdata;
				REG_DUTY_GAIN: duty_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || m_tready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTG];

	// Quadrant fold for both lanes; cos(h) is sin(h + quarter turn).
	logic signed [SPEED_W-1:0] speed;
	logic [HEAD_W-1:0]         heading;
	logic [14:0]               off_dir;
	logic [14:0]               off_rev;
	logic [Q_W-1:0]            x_sin;
	logic [Q_W-1:0]            x_cos;

	assign speed   = $signed(s_tdata[SPEED_W-1:0]);
	assign heading = s_tdata[SPEED_W+HEAD_W-1:SPEED_W];
	assign off_dir = {1'b0, heading[13:0]};
	assign off_rev = 15'd16384 - off_dir;
	assign x_sin   = {(heading[14] ? off_rev : off_dir), 16'd0};
	assign x_cos   = {(heading[14] ? off_dir : off_rev), 16'd0};

	logic [Q_W-1:0]            xs_s1, xc_s1;
	logic                      ns_s1, nc_s1;
	logic signed [SPEED_W-1:0] v_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xs_s1 <= x_sin;
			xc_s1 <= x_cos;
			ns_s1 <= heading[15];
			nc_s1 <= heading[15] ^ heading[14];
			v_s1  <= speed;
		end
	end

	logic [2*Q_W-1:0]          xxs, xxc;
	logic [Q_W-1:0]            xs_s2, xc_s2, x2s_s2, x2c_s2;

	assign xxs = (2*Q_W)'(xs_s1) * (2*Q_W)'(xs_s1);
	assign xxc = (2*Q_W)'(xc_s1) * (2*Q_W)'(xc_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			xs_s2  <= xs_s1;
			xc_s2  <= xc_s1;
			x2s_s2 <= xxs[2*Q_W-2:Q_W-1];
			x2c_s2 <= xxc[2*Q_W-2:Q_W-1];
		end
	end

	// Sideband carried beside the Horner cells, one entry per stage.
	logic signed [SPEED_W-1:0] v_s [2:CELL0+HORNER_CELLS-1];
	logic                      ns_s [2:CELL0+HORNER_CELLS-1];
	logic                      nc_s [2:CELL0+HORNER_CELLS-1];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			v_s[2]  <= v_s1;
			ns_s[2] <= ns_s1;
			nc_s[2] <= nc_s1;
		end
		for (int k = 3; k <= CELL0 + HORNER_CELLS - 1; k++) begin
			if (en[k]) begin
				v_s[k]  <= v_s[k-1];
				ns_s[k] <= ns_s[k-1];
				nc_s[k] <= nc_s[k-1];
			end
		end
	end

	logic [Q_W-1:0] cs_x [HORNER_CELLS+1];
	logic [Q_W-1:0] cs_x2 [HORNER_CELLS+1];
	logic [Q_W-1:0] cs_t [HORNER_CELLS+1];
	logic [Q_W-1:0] cc_x [HORNER_CELLS+1];
	logic [Q_W-1:0] cc_x2 [HORNER_CELLS+1];
	logic [Q_W-1:0] cc_t [HORNER_CELLS+1];

	assign cs_x[0]  = xs_s2;
	assign cs_x2[0] = x2s_s2;
	assign cs_t[0]  = SIN_C11;
	assign cc_x[0]  = xc_s2;
	assign cc_x2[0] = x2c_s2;
	assign cc_t[0]  = SIN_C11;

	for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_cell
		owsp_horner_cell #(
			.COEF(HORNER_COEF[k])
		) u_sin (
			.clk(clk), .en(en[CELL0+k]),
			.x_in(cs_x[k]), .x2_in(cs_x2[k]), .t_in(cs_t[k]),
			.x_out(cs_x[k+1]), .x2_out(cs_x2[k+1]), .t_out(cs_t[k+1])
		);
		owsp_horner_cell #(
			.COEF(HORNER_COEF[k])
		) u_cos (
			.clk(clk), .en(en[CELL0+k]),
			.x_in(cc_x[k]), .x2_in(cc_x2[k]), .t_in(cc_t[k]),
			.x_out(cc_x[k+1]), .x2_out(cc_x2[k+1]), .t_out(cc_t[k+1])
		);
	end

	function automatic logic signed [TRIG_BITS-1:0] sine_out(
		input logic [Q_W-1:0] x,
		input logic [Q_W-1:0] t,
		input logic           neg
	);
		logic [2*Q_W-1:0]          prod;
		logic [31:0]               q;
		logic [TRIG_BITS:0]        m;
		logic signed [TRIG_BITS-1:0] r;
		prod = (2*Q_W)'(x) * (2*Q_W)'(t);
		q    = prod[2*Q_W-1:Q_W-1];
		m    = q[31:31-TRIG_BITS];
		if (m > SIN_TOP) begin
			m = SIN_TOP;
		end
		r = $signed({1'b0, m[TRIG_BITS-2:0]});
		return neg ? -r : r;
	endfunction

	localparam int LAST = CELL0 + HORNER_CELLS - 1;

	logic signed [TRIG_BITS-1:0] sin_s8, cos_s8;
	logic signed [SPEED_W-1:0]   v_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			sin_s8 <= sine_out(cs_x[HORNER_CELLS], cs_t[HORNER_CELLS], ns_s[LAST]);
			cos_s8 <= sine_out(cc_x[HORNER_CELLS], cc_t[HORNER_CELLS], nc_s[LAST]);
			v_s8   <= v_s[LAST];
		end
	end

	logic signed [VC_W-1:0] vs_s9, vc_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			vs_s9 <= VC_W'(v_s8) * VC_W'(sin_s8);
			vc_s9 <= VC_W'(v_s8) * VC_W'(cos_s8);
		end
	end

	logic signed [SUM_W-1:0] cpart_s10;
	logic signed [VC_W-1:0]  vs_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			cpart_s10 <= SUM_W'(vc_s9) * K_SQ3;
			vs_s10    <= vs_s9;
		end
	end

	logic signed [SUM_W-1:0] spart;
	logic signed [SUM_W-1:0] sum_a_s11, sum_b_s11, sum_c_s11;

	assign spart = SUM_W'(vs_s10) <<< 15;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			sum_a_s11 <= spart - cpart_s10;
			sum_b_s11 <= -(SUM_W'(vs_s10) <<< 16);
			sum_c_s11 <= spart + cpart_s10;
		end
	end

	owsp_wheel_ctrl_t wctrl;

	assign wctrl.en_abs = en[12];
	assign wctrl.en_mul = en[13];
	assign wctrl.en_sum = en[14];
	assign wctrl.en_out = en[15];

	logic [RPM_W-1:0]  rpm_a, rpm_b, rpm_c;
	logic [DUTY_W-1:0] duty_a, duty_b, duty_c;
	logic              fwd_a, fwd_b, fwd_c;

	owsp_wheel #(.TRIG_BITS(TRIG_BITS)) u_wheel_a (
		.clk(clk), .ctrl(wctrl), .sum(sum_a_s11),
		.rpm_gain(rpm_gain_q), .duty_gain(duty_gain_q),
		.rpm(rpm_a), .duty(duty_a), .fwd(fwd_a)
	);

	owsp_wheel #(.TRIG_BITS(TRIG_BITS)) u_wheel_b (
		.clk(clk), .ctrl(wctrl), .sum(sum_b_s11),
		.rpm_gain(rpm_gain_q), .duty_gain(duty_gain_q),
		.rpm(rpm_b), .duty(duty_b), .fwd(fwd_b)
	);

	owsp_wheel #(.TRIG_BITS(TRIG_BITS)) u_wheel_c (
		.clk(clk), .ctrl(wctrl), .sum(sum_c_s11),
		.rpm_gain(rpm_gain_q), .duty_gain(duty_gain_q),
		.rpm(rpm_c), .duty(duty_c), .fwd(fwd_c)
	);

	assign m_tdata = {4'd0, fwd_c, fwd_b, fwd_a, duty_c, duty_b, duty_a,
		rpm_c, rpm_b, rpm_a};

endmodule

FILE: design/owsp_horner_cell.sv
// ---------------------------------------------------------------------------
// owsp_horner_cell
// One Horner step of the quarter-wave sine: t_out = COEF - (x2 * t_in) >> 30.
// ---------------------------------------------------------------------------
module owsp_horner_cell
	import owsp_pkg::*;
#(
	parameter logic [30:0] COEF = 31'd0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [Q_W-1:0] x_in,
	input  logic [Q_W-1:0] x2_in,
	input  logic [Q_W-1:0] t_in,
	output logic [Q_W-1:0] x_out,
	output logic [Q_W-1:0] x2_out,
	output logic [Q_W-1:0] t_out
);

	logic [2*Q_W-1:0] prod;
	logic [Q_W-1:0]   x_s1;
	logic [Q_W-1:0]   x2_s1;
	logic [Q_W-1:0]   t_s1;

	assign prod = (2*Q_W)'(x2_in) * (2*Q_W)'(t_in);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_in;
			x2_s1 <= x2_in;
			t_s1  <= COEF - prod[2*Q_W-2:Q_W-1];
		end
	end

	assign x_out  = x_s1;
	assign x2_out = x2_s1;
	assign t_out  = t_s1;

endmodule

FILE: design/owsp_wheel.sv
// ---------------------------------------------------------------------------
// owsp_wheel
// Turns one wheel sum into saturated rpm, PWM duty and direction bit.
// ---------------------------------------------------------------------------
module owsp_wheel
	import owsp_pkg::*;
#(
	parameter int TRIG_BITS = 16
) (
	input  logic                                clk,
	input  owsp_wheel_ctrl_t                    ctrl,
	input  logic signed [TRIG_BITS+SUM_GUARD-1:0] sum,
	input  logic [GAIN_W-1:0]                   rpm_gain,
	input  logic [GAIN_W-1:0]                   duty_gain,
	output logic [RPM_W-1:0]                    rpm,
	output logic [DUTY_W-1:0]                   duty,
	output logic                                fwd
);

	localparam int SUM_W = TRIG_BITS + SUM_GUARD;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int TOT_W = SUM_W + GAIN_W;

	logic [SUM_W-1:0]        mag_s1;
	logic                    neg_s1;
	logic [LO_W+GAIN_W-1:0]  pl_s2;
	logic [HI_W+GAIN_W-1:0]  ph_s2;
	logic                    neg_s2;
	logic [TOT_W-1:0]        tot;
	logic [P_W-1:0]          p_s3;
	logic                    neg_s3;
	logic [P_W+GAIN_W-1:0]   dfull;
	logic [P_W-1:0]          dval;
	logic [P_W-1:0]          pm;
	logic [P_W-1:0]          pn;
	logic [RPM_W-1:0]        rpm_s4;
	logic [DUTY_W-1:0]       duty_s4;
	logic                    fwd_s4;

	always_ff @(posedge clk) begin
		if (ctrl.en_abs) begin
			neg_s1 <= sum[SUM_W-1];
			mag_s1 <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_mul) begin
			pl_s2  <= (LO_W+GAIN_W)'(mag_s1[LO_W-1:0]) * (LO_W+GAIN_W)'(rpm_gain);
			ph_s2  <= (HI_W+GAIN_W)'(mag_s1[SUM_W-1:LO_W]) * (HI_W+GAIN_W)'(rpm_gain);
			neg_s2 <= neg_s1;
		end
	end

	assign tot = (TOT_W'(ph_s2) << LO_W) + TOT_W'(pl_s2);

	always_ff @(posedge clk) begin
		if (ctrl.en_sum) begin
			p_s3   <= P_W'(tot >> (TRIG_BITS + 31));
			neg_s3 <= neg_s2;
		end
	end

	always_comb begin
		dfull = (P_W+GAIN_W)'(p_s3) * (P_W+GAIN_W)'(duty_gain);
		dval  = dfull[P_W+GAIN_W-1:GAIN_W];
		if (dval > DUTY_MAX) begin
			dval = DUTY_MAX;
		end
		pm = p_s3;
		if (neg_s3 && p_s3 != '0) begin
			if (pm > RPM_NEG_MAX) begin
				pm = RPM_NEG_MAX;
			end
		end else if (pm > RPM_POS_MAX) begin
			pm = RPM_POS_MAX;
		end
		pn = P_W'(0) - pm;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_out) begin
			duty_s4 <= dval[DUTY_W-1:0];
			if (neg_s3 && p_s3 != '0) begin
				rpm_s4 <= pn[RPM_W-1:0];
				fwd_s4 <= 1'b0;
			end else begin
				rpm_s4 <= pm[RPM_W-1:0];
				fwd_s4 <= 1'b1;
			end
		end
	end

	assign rpm  = rpm_s4;
	assign duty = duty_s4;
	assign fwd  = fwd_s4;

endmodule

FILE: design/owsp_checker.sv
// ---------------------------------------------------------------------------
// owsp_checker
// Port-level checks on the result channel of omni_wheel_speed_to_pwm.
// ---------------------------------------------------------------------------
`include "omni_wheel_speed_to_pwm_macros.svh"

module owsp_checker
	import owsp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`OWSP_CHECK_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	`OWSP_CHECK_NOW(a_fwd_sign, m_tvalid, (m_tdata[57] == !m_tdata[10]) && (m_tdata[58] == !m_tdata[21]) && (m_tdata[59] == !m_tdata[32]))

	`OWSP_CHECK_NOW(a_zero_duty, m_tvalid && (m_tdata[10:0] == 11'd0 || m_tdata[21:11] == 11'd0), (m_tdata[10:0] != 11'd0 || m_tdata[40:33] == 8'd0) && (m_tdata[21:11] != 11'd0 || m_tdata[48:41] == 8'd0))

	`OWSP_CHECK_NOW(a_pad_zero, m_tvalid, m_tdata[63:60] == 4'd0)

endmodule

bind omni_wheel_speed_to_pwm owsp_checker u_owsp_checker (.*);
